@@ rtl/psi_pkg.sv @@
// ----------------------------------------------------------------------------
// psi_pkg
// Shared types and codes for the priority scheduler with inheritance.
// ----------------------------------------------------------------------------
package psi_pkg;

	localparam int TIME_W = 16;
	localparam int PRI_W  = 8;
	localparam int IDX_W  = 3;
	localparam int POL_W  = 2;
	localparam int EV_W   = 3;
	localparam int CNT_W  = 4;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// policies (code 3 behaves as plain priority)
	localparam logic [POL_W-1:0] POL_PLAIN   = 2'd0;
	localparam logic [POL_W-1:0] POL_NONPRE  = 2'd1;
	localparam logic [POL_W-1:0] POL_INHERIT = 2'd2;

	// task status
	localparam logic [1:0] TS_WAITING  = 2'd0;
	localparam logic [1:0] TS_BLOCKED  = 2'd1;
	localparam logic [1:0] TS_FINISHED = 2'd2;

	// events
	localparam logic [EV_W-1:0] EV_LOADED    = 3'd0;
	localparam logic [EV_W-1:0] EV_IDLE      = 3'd1;
	localparam logic [EV_W-1:0] EV_COMPUTING = 3'd2;
	localparam logic [EV_W-1:0] EV_ACQUIRED  = 3'd3;
	localparam logic [EV_W-1:0] EV_INCRIT    = 3'd4;
	localparam logic [EV_W-1:0] EV_RELEASED  = 3'd5;

	typedef struct packed {
		logic              opcode;
		logic [IDX_W-1:0]  task_index;
		logic [TIME_W-1:0] release_time;
		logic [TIME_W-1:0] exec_time;
		logic [PRI_W-1:0]  priority_req;
		logic              has_critical;
		logic [TIME_W-1:0] crit_start;
		logic [TIME_W-1:0] crit_length;
		logic [TIME_W-1:0] now;
	} in_item_t;

	typedef struct packed {
		logic [EV_W-1:0]  event_res;
		logic             task_valid;
		logic [IDX_W-1:0] running_task;
		logic             resource_on;
		logic [CNT_W-1:0] blocked_now;
		logic             priority_raised;
	} out_item_t;

	// static part of a task entry, written by a load only
	typedef struct packed {
		logic [TIME_W-1:0] rel;
		logic [TIME_W-1:0] exe;
		logic [PRI_W-1:0]  bpri;
		logic              cen;
		logic [TIME_W-1:0] cst;
		logic [TIME_W-1:0] clen;
	} task_rec_t;

	// critical-section phase of the task being run
	typedef struct packed {
		logic req;
		logic incrit;
		logic rel;
	} phase_t;

endpackage

@@ rtl/psi_chan_if.sv @@
// ----------------------------------------------------------------------------
// psi_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface psi_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/priority_scheduler_with_inheritance.sv @@
// ----------------------------------------------------------------------------
// priority_scheduler_with_inheritance
// Tick-driven fixed-priority task scheduler with one shared resource.
// ----------------------------------------------------------------------------
// A load transaction goes from the idle state straight to the output state. A
// tick first credits the task that was running, if any, and then selects a
// task: the selection scan reads one task entry at a time from the task
// memories, each through a read state and a compare state. Each denied
// resource request adds another scan; under inheritance the owner's priority
// is first read and raised if the blocked task's is higher. A transaction
// also waits in its output state while the previous result is still held. The block takes one
// transaction at a time; a finished result sits in the output register while
// the next transaction is taken. The policy register may be written only
// while the block is idle.
module priority_scheduler_with_inheritance #(
	parameter int NUM_TASKS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	psi_chan_if.sink                   item,
	psi_chan_if.source                 result,
	input  logic                       cfg_wr_en,
	input  logic [psi_pkg::POL_W-1:0]  cfg_wr_data
);
	import psi_pkg::*;

	localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
	localparam int BW = $clog2(NUM_TASKS + 1);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_CRD_RD  = 4'd1;
	localparam logic [3:0] S_CRED    = 4'd2;
	localparam logic [3:0] S_CHECK   = 4'd3;
	localparam logic [3:0] S_SCAN_RD = 4'd4;
	localparam logic [3:0] S_SCAN    = 4'd5;
	localparam logic [3:0] S_PICK    = 4'd6;
	localparam logic [3:0] S_RUN_RD  = 4'd7;
	localparam logic [3:0] S_RUN     = 4'd8;
	localparam logic [3:0] S_OWN_RD  = 4'd9;
	localparam logic [3:0] S_OWN     = 4'd10;
	localparam logic [3:0] S_OUT     = 4'd11;

	// task memories
	task_rec_t         rec_mem  [NUM_TASKS];
	logic [PRI_W-1:0]  cpri_mem [NUM_TASKS];
	logic [TIME_W-1:0] ext_mem  [NUM_TASKS];

	task_rec_t         rd_rec_q;
	logic [PRI_W-1:0]  rd_cpri_q;
	logic [TIME_W-1:0] rd_ext_q;

	logic [3:0]        state_q;
	logic [TW-1:0]     addr_q;
	logic [TW-1:0]     cur_task_q;
	logic              cur_valid_q;
	logic              busy_q;
	logic [TW-1:0]     owner_q;
	logic              own_vld_q;
	logic [POL_W-1:0]  policy_q;
	logic              found_q;
	logic [TW-1:0]     best_q;
	logic [PRI_W-1:0]  bestp_q;
	logic              held_q;
	logic [EV_W-1:0]   ev_q;
	logic              ran_q;
	logic [BW-1:0]     blk_q;
	logic              rsd_q;
	logic [TIME_W-1:0] now_q;
	logic [PRI_W-1:0]  tmp_q;
	logic [1:0]        status_q [NUM_TASKS];
	logic              out_valid_q;
	out_item_t         out_data_q;

	logic              accept;
	logic              load_we;
	logic [TW-1:0]     load_idx;
	logic              cpri_we;
	logic [TW-1:0]     cpri_wa;
	logic [PRI_W-1:0]  cpri_wd;
	logic              ext_we;
	logic [TW-1:0]     ext_wa;
	logic [TIME_W-1:0] ext_wd;
	logic [TIME_W-1:0] ext_inc;
	logic              cand;
	logic              owner_hit;
	logic              out_load;
	phase_t            phase;

	assign item.ready   = (state_q == S_IDLE);
	assign accept       = item.valid && item.ready;
	assign load_idx     = TW'(item.data.task_index);
	assign load_we      = accept && (item.data.opcode == OP_LOAD) &&
		(int'(item.data.task_index) < NUM_TASKS);
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;
	assign out_load     = (state_q == S_OUT) && (!out_valid_q || result.ready);

	assign ext_inc   = (rd_ext_q == '1) ? rd_ext_q : rd_ext_q + TIME_W'(1);
	assign owner_hit = own_vld_q && (owner_q == cur_task_q);
	assign cand      = (rd_rec_q.rel <= now_q) && (status_q[addr_q] == TS_WAITING) &&
		(!found_q || (rd_cpri_q < bestp_q));

	psi_eval u_eval (
		.cen      (rd_rec_q.cen),
		.executed (rd_ext_q),
		.cst      (rd_rec_q.cst),
		.clen     (rd_rec_q.clen),
		.phase    (phase)
	);

	always_comb begin
		cpri_we = 1'b0;
		cpri_wa = load_idx;
		cpri_wd = item.data.priority_req;
		ext_we  = 1'b0;
		ext_wa  = load_idx;
		ext_wd  = '0;
		if (load_we) begin
			cpri_we = 1'b1;
			ext_we  = 1'b1;
		end
		if (state_q == S_CRED) begin
			ext_we = 1'b1;
			ext_wa = addr_q;
			ext_wd = ext_inc;
		end
		if (state_q == S_OWN && tmp_q < rd_cpri_q) begin
			cpri_we = 1'b1;
			cpri_wa = owner_q;
			cpri_wd = tmp_q;
		end
		if (state_q == S_RUN && phase.rel && owner_hit && policy_q == POL_INHERIT) begin
			cpri_we = 1'b1;
			cpri_wa = cur_task_q;
			cpri_wd = rd_rec_q.bpri;
		end
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			rec_mem[load_idx] <= '{rel: item.data.release_time, exe: item.data.exec_time,
				bpri: item.data.priority_req, cen: item.data.has_critical,
				cst: item.data.crit_start, clen: item.data.crit_length};
		end
		if (cpri_we) begin
			cpri_mem[cpri_wa] <= cpri_wd;
		end
		if (ext_we) begin
			ext_mem[ext_wa] <= ext_wd;
		end
		rd_rec_q  <= rec_mem[addr_q];
		rd_cpri_q <= cpri_mem[addr_q];
		rd_ext_q  <= ext_mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			addr_q      <= '0;
			cur_task_q  <= '0;
			cur_valid_q <= 1'b0;
			busy_q      <= 1'b0;
			owner_q     <= '0;
			own_vld_q   <= 1'b0;
			policy_q    <= POL_PLAIN;
			found_q     <= 1'b0;
			best_q      <= '0;
			bestp_q     <= '0;
			held_q      <= 1'b0;
			ev_q        <= EV_IDLE;
			ran_q       <= 1'b0;
			blk_q       <= '0;
			rsd_q       <= 1'b0;
			now_q       <= '0;
			tmp_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			for (int i = 0; i < NUM_TASKS; i++) begin
				status_q[i] <= TS_FINISHED;
			end
		end else begin
			if (cfg_wr_en) begin
				policy_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ev_q  <= (item.data.opcode == OP_LOAD) ? EV_LOADED : EV_IDLE;
						ran_q <= 1'b0;
						blk_q <= '0;
						rsd_q <= 1'b0;
						now_q <= item.data.now;
						if (item.data.opcode == OP_LOAD) begin
							if (load_we) begin
								status_q[load_idx] <= TS_WAITING;
							end
							state_q <= S_OUT;
						end else if (cur_valid_q) begin
							addr_q  <= cur_task_q;
							state_q <= S_CRD_RD;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CRD_RD: begin
					state_q <= S_CRED;
				end
				S_CRED: begin
					if (ext_inc >= rd_rec_q.exe) begin
						status_q[addr_q] <= TS_FINISHED;
					end
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (policy_q == POL_NONPRE && busy_q) begin
						if (cur_valid_q) begin
							addr_q  <= cur_task_q;
							held_q  <= 1'b1;
							state_q <= S_RUN_RD;
						end else begin
							ev_q    <= EV_IDLE;
							ran_q   <= 1'b0;
							state_q <= S_OUT;
						end
					end else begin
						cur_valid_q <= 1'b0;
						found_q     <= 1'b0;
						best_q      <= '0;
						held_q      <= 1'b0;
						addr_q      <= '0;
						state_q     <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (cand) begin
						found_q <= 1'b1;
						best_q  <= addr_q;
						bestp_q <= rd_cpri_q;
					end
					if (addr_q == TW'(NUM_TASKS - 1)) begin
						state_q <= S_PICK;
					end else begin
						addr_q  <= addr_q + TW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_PICK: begin
					if (found_q) begin
						cur_valid_q <= 1'b1;
						cur_task_q  <= best_q;
						addr_q      <= best_q;
						state_q     <= S_RUN_RD;
					end else begin
						cur_task_q <= '0;
						ev_q       <= EV_IDLE;
						ran_q      <= 1'b0;
						state_q    <= S_OUT;
					end
				end
				S_RUN_RD: begin
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (phase.req && busy_q && !held_q) begin
						// denied: block and pick again
						ran_q <= 1'b0;
						ev_q  <= EV_COMPUTING;
						if (policy_q == POL_INHERIT && own_vld_q) begin
							tmp_q   <= rd_cpri_q;
							addr_q  <= owner_q;
							state_q <= S_OWN_RD;
						end else begin
							status_q[cur_task_q] <= TS_BLOCKED;
							blk_q                <= blk_q + BW'(1);
							state_q              <= S_CHECK;
						end
					end else begin
						ran_q   <= 1'b1;
						state_q <= S_OUT;
						if (phase.req) begin
							if (!busy_q) begin
								busy_q    <= 1'b1;
								owner_q   <= cur_task_q;
								own_vld_q <= 1'b1;
								ev_q      <= EV_ACQUIRED;
							end else begin
								ev_q <= EV_COMPUTING;
							end
						end else if (phase.incrit) begin
							ev_q <= EV_INCRIT;
						end else if (phase.rel) begin
							ev_q <= EV_RELEASED;
							if (owner_hit) begin
								busy_q    <= 1'b0;
								own_vld_q <= 1'b0;
								owner_q   <= '0;
								if (policy_q == POL_INHERIT) begin
									for (int i = 0; i < NUM_TASKS; i++) begin
										if (status_q[i] == TS_BLOCKED) begin
											status_q[i] <= TS_WAITING;
										end
									end
								end
							end
						end else begin
							ev_q <= EV_COMPUTING;
						end
					end
				end
				S_OWN_RD: begin
					state_q <= S_OWN;
				end
				S_OWN: begin
					if (tmp_q < rd_cpri_q) begin
						rsd_q <= 1'b1;
					end
					status_q[cur_task_q] <= TS_BLOCKED;
					blk_q                <= blk_q + BW'(1);
					state_q              <= S_CHECK;
				end
				S_OUT: begin
					if (out_load) begin
						out_data_q.event_res       <= ev_q;
						out_data_q.task_valid      <= ran_q;
						out_data_q.running_task    <= ran_q ? IDX_W'(cur_task_q) : '0;
						out_data_q.resource_on     <= busy_q;
						out_data_q.blocked_now     <= CNT_W'(blk_q);
						out_data_q.priority_raised <= rsd_q;
						state_q                    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/psi_eval.sv @@
// ----------------------------------------------------------------------------
// psi_eval
// Classifies the executed-tick count of a task against its critical section.
// ----------------------------------------------------------------------------
module psi_eval (
	input  logic                        cen,
	input  logic [psi_pkg::TIME_W-1:0]  executed,
	input  logic [psi_pkg::TIME_W-1:0]  cst,
	input  logic [psi_pkg::TIME_W-1:0]  clen,
	output psi_pkg::phase_t             phase
);
	import psi_pkg::*;

	logic signed [TIME_W+1:0] e_x;
	logic signed [TIME_W+1:0] s_x;
	logic signed [TIME_W+1:0] end_x;

	assign e_x   = signed'({2'b00, executed});
	assign s_x   = signed'({2'b00, cst});
	assign end_x = s_x + signed'({2'b00, clen}) - (TIME_W+2)'(1);

	// request test wins over release test
	always_comb begin
		phase.req    = cen && (e_x == s_x);
		phase.incrit = cen && !phase.req && (e_x > s_x) && (e_x < end_x);
		phase.rel    = cen && !phase.req && !phase.incrit && (e_x == end_x);
	end

endmodule

@@ rtl/psi_check.sv @@
// ----------------------------------------------------------------------------
// psi_check
// Port-level checks on the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module psi_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input psi_pkg::out_item_t out_data
);
	import psi_pkg::*;

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one transaction in flight
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("transaction taken while busy");

	a_load_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_res == EV_LOADED |->
		!out_data.task_valid && out_data.blocked_now == '0 && !out_data.priority_raised)
		else $error("load result carries tick information");

	a_idle_no_task: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.task_valid |->
		out_data.running_task == '0 &&
		(out_data.event_res == EV_LOADED || out_data.event_res == EV_IDLE))
		else $error("no task ran but a task event was reported");

	a_run_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.task_valid |->
		out_data.event_res != EV_LOADED && out_data.event_res != EV_IDLE)
		else $error("task ran with an idle or load event");

endmodule

bind priority_scheduler_with_inheritance psi_check u_psi_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority scheduler with inheritance. Task
// loads and scheduler ticks go in over a valid/ready channel. A behavioural
// copy of the scheduler kept in the bench predicts the outcome of every
// transaction, and each result is checked field by field in arrival order.
// Directed cases come first, then random scenarios under all policies with
// varying handshake idling and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
	import psi_pkg::*;

	localparam int NUM_TASKS   = 8;
	localparam int NO_PRIORITY = 1000;
	localparam int LIMIT       = 1000000;
	localparam logic [POL_W-1:0] POL_UNKNOWN = 2'd3;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [POL_W-1:0] cfg_wr_data;

	psi_chan_if #(.payload_t(in_item_t))  item_if ();
	psi_chan_if #(.payload_t(out_item_t)) res_if ();

	priority_scheduler_with_inheritance #(.NUM_TASKS(NUM_TASKS)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_if),
		.result      (res_if),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// scheduler state as the bench sees it
	task_rec_t         task_tab   [NUM_TASKS];
	logic [PRI_W-1:0]  cur_pri    [NUM_TASKS];
	logic [1:0]        task_state [NUM_TASKS];
	logic [TIME_W-1:0] done_ticks [NUM_TASKS];
	int                run_idx;
	bit                run_ok;
	bit                res_busy;
	int                res_owner;
	bit                owner_ok;
	logic [POL_W-1:0]  pol;

	out_item_t pending_outcomes [$];
	int items_sent;
	int mismatches;
	int hold_left;
	int send_idle;
	int recv_idle;
	int cycle_count;

	// one tick of work for task t; flags a refused resource request
	function automatic logic [EV_W-1:0] run_one(input int t, output bit denied,
		inout bit raised);
		int e, s, e_last;
		denied = 1'b0;
		e = int'(done_ticks[t]);
		s = int'(task_tab[t].cst);
		e_last = s + int'(task_tab[t].clen) - 1;
		if (!task_tab[t].cen)
			return EV_COMPUTING;
		if (e == s) begin
			if (!res_busy) begin
				res_busy = 1'b1;
				res_owner = t;
				owner_ok = 1'b1;
				return EV_ACQUIRED;
			end
			if (pol == POL_INHERIT && owner_ok && cur_pri[t] < cur_pri[res_owner]) begin
				cur_pri[res_owner] = cur_pri[t];
				raised = 1'b1;
			end
			denied = 1'b1;
			return EV_COMPUTING;
		end
		if (e > s && e < e_last)
			return EV_INCRIT;
		if (e == e_last) begin
			if (owner_ok && res_owner == t) begin
				res_busy = 1'b0;
				owner_ok = 1'b0;
				res_owner = 0;
				if (pol == POL_INHERIT) begin
					cur_pri[t] = task_tab[t].bpri;
					for (int j = 0; j < NUM_TASKS; j++)
						if (task_state[j] == TS_BLOCKED)
							task_state[j] = TS_WAITING;
				end
			end
			return EV_RELEASED;
		end
		return EV_COMPUTING;
	endfunction

	function automatic out_item_t schedule_step(input in_item_t it);
		out_item_t r;
		logic [EV_W-1:0] ev;
		bit ran, denied, raised;
		int blocked, best, bestp, c;
		ev = EV_IDLE;
		ran = 1'b0;
		raised = 1'b0;
		blocked = 0;
		if (it.opcode == OP_LOAD) begin
			c = int'(it.task_index);
			task_tab[c].rel  = it.release_time;
			task_tab[c].exe  = it.exec_time;
			task_tab[c].bpri = it.priority_req;
			task_tab[c].cen  = it.has_critical;
			task_tab[c].cst  = it.crit_start;
			task_tab[c].clen = it.crit_length;
			cur_pri[c] = it.priority_req;
			done_ticks[c] = '0;
			task_state[c] = TS_WAITING;
			ev = EV_LOADED;
		end else begin
			if (run_ok) begin
				c = run_idx;
				if (done_ticks[c] != 16'hFFFF)
					done_ticks[c] = done_ticks[c] + 1'b1;
				if (done_ticks[c] >= task_tab[c].exe)
					task_state[c] = TS_FINISHED;
			end
			for (int k = 0; k <= NUM_TASKS; k++) begin
				if (pol == POL_NONPRE && res_busy) begin
					if (run_ok) begin
						ev = run_one(run_idx, denied, raised);
						ran = 1'b1;
					end else
						ev = EV_IDLE;
					break;
				end
				best = 0;
				bestp = NO_PRIORITY;
				run_ok = 1'b0;
				for (int i = 0; i < NUM_TASKS; i++) begin
					if (task_tab[i].rel <= it.now && task_state[i] == TS_WAITING &&
						int'(cur_pri[i]) < bestp) begin
						best = i;
						bestp = int'(cur_pri[i]);
						run_ok = 1'b1;
					end
				end
				if (!run_ok) begin
					run_idx = 0;
					ev = EV_IDLE;
					ran = 1'b0;
					break;
				end
				run_idx = best;
				ev = run_one(best, denied, raised);
				if (!denied) begin
					ran = 1'b1;
					break;
				end
				task_state[best] = TS_BLOCKED;
				blocked++;
			end
		end
		r.event_res       = ev;
		r.task_valid      = ran;
		r.running_task    = ran ? IDX_W'(run_idx) : '0;
		r.resource_on     = res_busy;
		r.blocked_now     = CNT_W'(blocked);
		r.priority_raised = raised;
		return r;
	endfunction

	function automatic in_item_t random_item();
		in_item_t r;
		r.opcode       = 1'($urandom_range(1));
		r.task_index   = IDX_W'($urandom_range(NUM_TASKS - 1));
		r.release_time = TIME_W'($urandom);
		r.exec_time    = TIME_W'($urandom);
		r.priority_req = PRI_W'($urandom);
		r.has_critical = 1'($urandom_range(1));
		r.crit_start   = TIME_W'($urandom);
		r.crit_length  = TIME_W'($urandom);
		r.now          = TIME_W'($urandom);
		return r;
	endfunction

	function automatic in_item_t load_item(input int idx, input logic [TIME_W-1:0] rel, exe,
		input logic [PRI_W-1:0] pri, input logic cen, input logic [TIME_W-1:0] cst, clen);
		in_item_t r;
		r = random_item();
		r.opcode       = OP_LOAD;
		r.task_index   = IDX_W'(idx);
		r.release_time = rel;
		r.exec_time    = exe;
		r.priority_req = pri;
		r.has_critical = cen;
		r.crit_start   = cst;
		r.crit_length  = clen;
		return r;
	endfunction

	function automatic in_item_t tick_item(input logic [TIME_W-1:0] now_val);
		in_item_t r;
		r = random_item();
		r.opcode = OP_TICK;
		r.now    = now_val;
		return r;
	endfunction

	// short task with small times, released near base
	function automatic in_item_t random_task(input int idx, input int base);
		logic [TIME_W-1:0] exe;
		logic [PRI_W-1:0]  pri;
		exe = ($urandom_range(9) == 0) ? TIME_W'($urandom_range(40)) : TIME_W'($urandom_range(8));
		pri = ($urandom_range(9) < 7) ? PRI_W'($urandom_range(7)) : PRI_W'($urandom);
		return load_item(idx, TIME_W'(base + $urandom_range(6)), exe, pri,
			$urandom_range(99) < 75, TIME_W'($urandom_range(4)), TIME_W'($urandom_range(5)));
	endfunction

	function automatic logic [POL_W-1:0] random_policy();
		int roll;
		roll = $urandom_range(9);
		if (roll < 3)
			return POL_PLAIN;
		else if (roll < 6)
			return POL_NONPRE;
		else if (roll < 9)
			return POL_INHERIT;
		else
			return POL_UNKNOWN;
	endfunction

	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle) begin
			@(negedge clk);
			item_if.valid <= 1'b0;
		end
		@(negedge clk);
		item_if.valid <= 1'b1;
		item_if.data  <= it;
		@(posedge clk);
		while (!item_if.ready)
			@(posedge clk);
		pending_outcomes.push_back(schedule_step(it));
		items_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		item_if.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_policy(input logic [POL_W-1:0] p);
		drain();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= p;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		pol = p;
	endtask

	// never released while ticks stay below the top of the time range
	task automatic park_task(input int idx);
		send_item(load_item(idx, 16'hFFFF, 16'd1, 8'hFF, 1'b0, 16'd0, 16'd1));
	endtask

	task automatic run_scenario();
		int base, now_t, nticks, roll, owner;
		bit pick [NUM_TASKS];
		// mostly free a stuck resource first, else carry it into the next policy
		if (res_busy && $urandom_range(3) != 0) begin
			owner = res_owner;
			set_policy(POL_PLAIN);
			for (int i = 0; i < NUM_TASKS; i++)
				if (task_state[i] != TS_FINISHED || i == owner)
					park_task(i);
			send_item(tick_item(16'd0));
			send_item(load_item(owner, 16'd0, 16'd3, 8'd0, 1'b1, 16'd1, 16'd0));
			send_item(tick_item(16'd0));
		end
		set_policy(random_policy());
		base = $urandom_range(1000);
		for (int i = 0; i < NUM_TASKS; i++)
			pick[i] = ($urandom_range(99) < 60);
		for (int i = 0; i < NUM_TASKS; i++) begin
			if (pick[i])
				send_item(random_task(i, base));
			else if (task_state[i] != TS_FINISHED)
				park_task(i);
		end
		nticks = $urandom_range(36, 12);
		now_t = base;
		for (int k = 0; k < nticks; k++) begin
			roll = $urandom_range(99);
			if (roll < 6)
				send_item(random_item());
			else if (roll < 14)
				send_item(random_task($urandom_range(NUM_TASKS - 1), now_t));
			else if (roll < 17)
				set_policy(random_policy());
			else begin
				send_item(tick_item(TIME_W'(now_t)));
				now_t += ($urandom_range(9) == 0) ? 3 : 1;
			end
		end
	endtask

	task automatic run_random(input int sidle, input int ridle, input int target);
		send_idle = sidle;
		recv_idle = ridle;
		while (items_sent < target)
			run_scenario();
	endtask

	task automatic test_plain_extremes();
		send_item(tick_item(16'd0));
		send_item(load_item(7, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF));
		send_item(tick_item(16'd0));
		send_item(tick_item(16'hFFFF));
		// zero run time, zero-length section
		send_item(load_item(0, 16'd0, 16'd0, 8'd0, 1'b1, 16'd0, 16'd0));
		send_item(tick_item(16'd1));
		// one-tick section: acquires, never releases
		send_item(load_item(1, 16'd0, 16'd3, 8'd5, 1'b1, 16'd0, 16'd1));
		send_item(tick_item(16'd2));
		// release by a task that does not own the resource
		send_item(load_item(2, 16'd0, 16'd2, 8'd1, 1'b1, 16'd1, 16'd0));
		send_item(tick_item(16'd3));
		send_item(tick_item(16'd4));
	endtask

	task automatic test_inheritance();
		set_policy(POL_INHERIT);
		send_item(load_item(3, 16'd0, 16'd8, 8'd0, 1'b1, 16'd0, 16'd2));
		send_item(load_item(0, 16'd0, 16'd8, 8'd100, 1'b1, 16'd5, 16'd0));
		for (int k = 5; k < 12; k++)
			send_item(tick_item(TIME_W'(k)));
	endtask

	task automatic test_non_preemptive();
		set_policy(POL_NONPRE);
		send_item(load_item(3, 16'd0, 16'd4, 8'd0, 1'b1, 16'd1, 16'd4));
		for (int k = 12; k < 17; k++)
			send_item(tick_item(TIME_W'(k)));
		set_policy(POL_UNKNOWN);
		send_item(tick_item(16'd17));
		send_item(tick_item(16'd18));
	endtask

	task automatic test_sender_idle();
		run_random(29, 47, 300);
	endtask

	task automatic test_receiver_idle();
		run_random(47, 29, 560);
	endtask

	task automatic test_back_pressure();
		send_idle = 0;
		recv_idle = 0;
		drain();
		hold_left = 400;
		for (int k = 0; k < 12; k++)
			send_item(tick_item(TIME_W'($urandom_range(2000))));
		drain();
		run_random(0, 0, 830);
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_if.ready <= 1'b0;
			hold_left--;
		end else
			res_if.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no transaction outstanding", $time);
			end else begin
				want = pending_outcomes.pop_front();
				if (res_if.data.event_res !== want.event_res ||
					res_if.data.task_valid !== want.task_valid ||
					res_if.data.running_task !== want.running_task ||
					res_if.data.resource_on !== want.resource_on ||
					res_if.data.blocked_now !== want.blocked_now ||
					res_if.data.priority_raised !== want.priority_raised) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch ev %0d/%0d run %0d:%0d/%0d:%0d res %0d/%0d blk %0d/%0d rai %0d/%0d",
							$time, res_if.data.event_res, want.event_res,
							res_if.data.task_valid, res_if.data.running_task,
							want.task_valid, want.running_task,
							res_if.data.resource_on, want.resource_on,
							res_if.data.blocked_now, want.blocked_now,
							res_if.data.priority_raised, want.priority_raised);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = POL_PLAIN;
		item_if.valid = 1'b0;
		item_if.data  = '0;
		res_if.ready  = 1'b0;
		items_sent    = 0;
		mismatches    = 0;
		hold_left     = 0;
		cycle_count   = 0;
		send_idle     = 29;
		recv_idle     = 47;
		for (int i = 0; i < NUM_TASKS; i++) begin
			task_tab[i]   = '0;
			cur_pri[i]    = '0;
			done_ticks[i] = '0;
			task_state[i] = TS_FINISHED;
		end
		run_idx   = 0;
		run_ok    = 1'b0;
		res_busy  = 1'b0;
		res_owner = 0;
		owner_ok  = 1'b0;
		pol       = POL_PLAIN;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_plain_extremes();
		test_inheritance();
		test_non_preemptive();
		test_sender_idle();
		test_receiver_idle();
		test_back_pressure();

		drain();
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/psi_pkg.sv
rtl/psi_chan_if.sv
rtl/psi_eval.sv
rtl/priority_scheduler_with_inheritance.sv
rtl/psi_check.sv
bench/tb_top.sv
